// ===== rtl/assert_macros.svh =====
// assertion macros used by bmpm_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define BMPM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("%m: assertion failed");

// clocked assertion that also holds during reset
`define BMPM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// ===== rtl/bmpm_pkg.sv =====
`default_nettype none

package bmpm_pkg;

    localparam int MAX_PATTERN_BITS = 16;
    localparam int MAX_PATTERNS     = 64;
    localparam int TABLE_DEPTH      = 1 << MAX_PATTERN_BITS;

    localparam int KIND_W = 2;
    localparam int LEN_W  = 5;
    localparam int ID_W   = 6;
    localparam int ENTRY_W = ID_W + 1;

    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEXT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    localparam logic [LEN_W-1:0] RESET_LEN = LEN_W'(MAX_PATTERN_BITS);

    typedef logic [MAX_PATTERN_BITS-1:0] t_pattern;
    typedef logic [ID_W-1:0]             t_id;
    typedef logic [LEN_W-1:0]            t_len;
    typedef logic [KIND_W-1:0]           t_kind;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic load_wr;
        logic text_shift;
        logic text_end;
        logic emit_none;
        logic emit_hit;
        logic scan_next;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic hits_zero;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/bmpm_if.sv =====
`default_nettype none

interface bmpm_in_if;
    import bmpm_pkg::*;
    logic     valid;
    logic     ready;
    t_kind    kind;
    t_pattern pattern_value;
    t_id      pattern_index;
    logic     text_bit;

    modport source (output valid, kind, pattern_value, pattern_index, text_bit,
                    input ready);
    modport sink   (input valid, kind, pattern_value, pattern_index, text_bit,
                    output ready);
endinterface

interface bmpm_out_if;
    import bmpm_pkg::*;
    logic valid;
    logic ready;
    t_id  match_index;
    logic none_found;
    logic last;

    modport source (output valid, match_index, none_found, last, input ready);
    modport sink   (input valid, match_index, none_found, last, output ready);
endinterface

interface bmpm_cfg_if;
    import bmpm_pkg::*;
    logic valid;
    logic ready;
    t_len pattern_length;

    modport source (output valid, pattern_length, input ready);
    modport sink   (input valid, pattern_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/bmpm_ctrl.sv =====
`default_nettype none

module bmpm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_item_valid,
    input  wire bmpm_pkg::t_kind i_kind,
    output logic                o_item_ready,
    input  wire bmpm_pkg::t_sts i_sts,
    output bmpm_pkg::t_cmd      o_cmd
);
    import bmpm_pkg::*;

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_RUN    = 2'd1;
    localparam logic [1:0] S_REPORT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_item_ready = (r_state == S_RUN);
    assign accept       = i_item_valid && o_item_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (accept) begin
                    unique case (i_kind)
                        KIND_LOAD: o_cmd.load_wr = 1'b1;
                        KIND_TEXT: o_cmd.text_shift = 1'b1;
                        KIND_END: begin
                            o_cmd.text_end = 1'b1;
                            n_state        = S_REPORT;
                        end
                        default: ;
                    endcase
                end
            end
            S_REPORT: begin
                priority if (i_sts.hits_zero) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_none = 1'b1;
                        n_state         = S_RUN;
                    end
                end else if (i_sts.scan_hit) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_hit = 1'b1;
                        if (i_sts.scan_last) begin
                            n_state = S_RUN;
                        end
                    end
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bmpm_dp.sv =====
`default_nettype none

module bmpm_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bmpm_pkg::t_cmd    i_cmd,
    output bmpm_pkg::t_sts         o_sts,
    input  wire bmpm_pkg::t_pattern i_pattern_value,
    input  wire bmpm_pkg::t_id     i_pattern_index,
    input  wire logic              i_text_bit,
    input  wire logic              i_cfg_we,
    input  wire bmpm_pkg::t_len    i_cfg_len,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output bmpm_pkg::t_id          o_match_index,
    output logic                   o_none_found,
    output logic                   o_last
);
    import bmpm_pkg::*;

    logic [ENTRY_W-1:0] r_mem [0:TABLE_DEPTH-1];
    logic [ENTRY_W-1:0] r_rd;

    t_len                    r_len;
    t_pattern                r_window;
    t_len                    r_bits;
    logic [MAX_PATTERNS-1:0] r_hit;
    t_id                     r_scan;
    t_pattern                r_clr_addr;
    logic                    r_lk_valid;

    t_len                    len_act;
    logic [MAX_PATTERN_BITS:0] mask_full;
    t_pattern                mask;
    t_pattern                n_window;
    t_len                    n_bits;
    t_pattern                rd_addr;
    t_pattern                wr_addr;
    logic [ENTRY_W-1:0]      wr_data;
    logic                    wr_en;
    logic [MAX_PATTERNS-1:0] scan_bit;
    logic [MAX_PATTERNS-1:0] n_hit;

    // clamp length to 1..MAX_PATTERN_BITS
    always_comb begin
        priority if (r_len == '0) begin
            len_act = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN_BITS)) begin
            len_act = LEN_W'(MAX_PATTERN_BITS);
        end else begin
            len_act = r_len;
        end
    end

    assign mask_full = ((MAX_PATTERN_BITS+1)'(1) << len_act) - (MAX_PATTERN_BITS+1)'(1);
    assign mask      = mask_full[MAX_PATTERN_BITS-1:0];

    assign n_window = {r_window[MAX_PATTERN_BITS-2:0], i_text_bit};
    assign n_bits   = (r_bits < LEN_W'(MAX_PATTERN_BITS)) ? r_bits + LEN_W'(1) : r_bits;
    assign rd_addr  = n_window & mask;

    assign wr_en   = i_cmd.clear_wr || i_cmd.load_wr;
    assign wr_addr = i_cmd.clear_wr ? r_clr_addr : (i_pattern_value & mask);
    assign wr_data = i_cmd.clear_wr ? '0 : {1'b1, i_pattern_index};

    // pattern table, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    assign scan_bit = MAX_PATTERNS'(1) << r_scan;

    always_comb begin
        n_hit = r_hit;
        if (r_lk_valid && r_rd[ENTRY_W-1]) begin
            n_hit = n_hit | (MAX_PATTERNS'(1) << r_rd[ID_W-1:0]);
        end
        if (i_cmd.emit_hit) begin
            n_hit = n_hit & ~scan_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= RESET_LEN;
            r_window    <= '0;
            r_bits      <= '0;
            r_hit       <= '0;
            r_scan      <= '0;
            r_clr_addr  <= '0;
            r_lk_valid  <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_len;
            end
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + MAX_PATTERN_BITS'(1);
            end
            r_lk_valid <= i_cmd.text_shift && (n_bits >= len_act);
            if (i_cmd.text_shift) begin
                r_window <= n_window;
                r_bits   <= n_bits;
            end else if (i_cmd.text_end) begin
                r_window <= '0;
                r_bits   <= '0;
            end
            r_hit <= n_hit;
            priority if (i_cmd.text_end) begin
                r_scan <= '0;
            end else if (i_cmd.emit_hit || i_cmd.scan_next) begin
                r_scan <= r_scan + ID_W'(1);
            end
            if (i_cmd.emit_hit || i_cmd.emit_none) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_hit) begin
            o_match_index <= r_scan;
            o_none_found  <= 1'b0;
            o_last        <= o_sts.scan_last;
        end else if (i_cmd.emit_none) begin
            o_match_index <= '0;
            o_none_found  <= 1'b1;
            o_last        <= 1'b1;
        end
    end

    assign o_sts.clear_done = (r_clr_addr == '1);
    assign o_sts.hits_zero  = (r_hit == '0);
    assign o_sts.scan_hit   = r_hit[r_scan];
    assign o_sts.scan_last  = ((r_hit & ~scan_bit) == '0);
    assign o_sts.out_free   = !o_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ===== rtl/binary_multi_pattern_matcher.sv =====
// input: load and text words are taken one word per cycle while input ready is high
// in the run state; a text lookup registers its table read, then sets its hit flag
// end-of-text report: one hit flag tested per cycle, holding while a found hit waits
// for the result output; each result word is registered when it is emitted
// reset: synchronous; a clearing pass writes all 65536 table entries, one per
// cycle, with input ready low; configuration writes are taken throughout
`default_nettype none

module binary_multi_pattern_matcher (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bmpm_in_if.sink     i_item,
    bmpm_cfg_if.sink    i_cfg,
    bmpm_out_if.source  o_result
);
    import bmpm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_item_ready;

    assign i_item.ready = w_item_ready;
    assign i_cfg.ready  = 1'b1;

    bmpm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .i_kind       (i_item.kind),
        .o_item_ready (w_item_ready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    bmpm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_pattern_value (i_item.pattern_value),
        .i_pattern_index (i_item.pattern_index),
        .i_text_bit      (i_item.text_bit),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_len       (i_cfg.pattern_length),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_match_index   (o_result.match_index),
        .o_none_found    (o_result.none_found),
        .o_last          (o_result.last)
    );

endmodule

`default_nettype wire

// ===== rtl/bmpm_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module bmpm_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_item_valid,
    input wire logic         i_item_ready,
    input wire logic         i_res_valid,
    input wire logic         i_res_ready,
    input wire bmpm_pkg::t_id i_res_index,
    input wire logic         i_res_none,
    input wire logic         i_res_last
);
    import bmpm_pkg::*;

    // table clearing keeps the input closed right after reset
    `BMPM_ASSERT_ALWAYS(a_closed_after_reset, i_clk, !i_rst_n |=> !i_item_ready)

    // a none-found word is the whole report
    `BMPM_ASSERT(a_none_shape, i_clk, i_rst_n,
        i_res_valid && i_res_none |-> i_res_last && (i_res_index == '0))

    // while a report is still going no new word comes in
    `BMPM_ASSERT(a_report_blocks, i_clk, i_rst_n,
        i_res_valid && !i_res_last |-> !(i_item_valid && i_item_ready))

    // a stalled result word holds
    `BMPM_ASSERT(a_res_hold, i_clk, i_rst_n,
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_index) && $stable(i_res_last))

endmodule

bind binary_multi_pattern_matcher bmpm_checker u_bmpm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_item_valid (i_item.valid),
    .i_item_ready (i_item.ready),
    .i_res_valid  (o_result.valid),
    .i_res_ready  (o_result.ready),
    .i_res_index  (o_result.match_index),
    .i_res_none   (o_result.none_found),
    .i_res_last   (o_result.last)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
    import bmpm_pkg::*;

    localparam t_kind KIND_UNUSED   = 2'd3;
    localparam int    LIMIT_CYCLES  = 600000;
    localparam int    SETTLE_CYCLES = 8;
    localparam int    TARGET_ITEMS  = 430;

    typedef struct {
        t_id  match_index;
        logic none_found;
        logic last;
    } t_report;

    // tracks the pattern table, the text window and the hit flags, and
    // holds the report words that the next end-of-text must produce
    class hit_tracker;
        logic [ENTRY_W-1:0]      pat_tab [TABLE_DEPTH];
        t_pattern                window;
        int                      bits_seen;
        logic [MAX_PATTERNS-1:0] hits;
        t_len                    length_reg;
        t_report                 pending_reports[$];
        int                      n_reports;
        int                      errors;

        function new();
            foreach (pat_tab[i]) pat_tab[i] = '0;
            window     = '0;
            bits_seen  = 0;
            hits       = '0;
            length_reg = RESET_LEN;
            n_reports  = 0;
            errors     = 0;
        endfunction

        function int active_bits();
            if (length_reg == '0) return 1;
            if (length_reg > MAX_PATTERN_BITS) return MAX_PATTERN_BITS;
            return int'(length_reg);
        endfunction

        function void take_item(t_kind kind, t_pattern value, t_id idx, logic bitv);
            t_pattern           mask;
            logic [ENTRY_W-1:0] entry;
            t_report            r;
            mask = t_pattern'((32'd1 << active_bits()) - 32'd1);
            case (kind)
                KIND_LOAD: pat_tab[value & mask] = {1'b1, idx};
                KIND_TEXT: begin
                    window = {window[MAX_PATTERN_BITS-2:0], bitv};
                    if (bits_seen < MAX_PATTERN_BITS) bits_seen++;
                    if (bits_seen >= active_bits()) begin
                        entry = pat_tab[window & mask];
                        if (entry[ENTRY_W-1]) hits[entry[ID_W-1:0]] = 1'b1;
                    end
                end
                KIND_END: begin
                    for (int i = 0; i < MAX_PATTERNS; i++) begin
                        if (hits[i]) begin
                            r.match_index = t_id'(i);
                            r.none_found  = 1'b0;
                            r.last        = ((hits >> (i + 1)) == '0);
                            pending_reports = {pending_reports, r};
                            n_reports++;
                        end
                    end
                    if (hits == '0) begin
                        r.match_index = '0;
                        r.none_found  = 1'b1;
                        r.last        = 1'b1;
                        pending_reports = {pending_reports, r};
                        n_reports++;
                    end
                    hits      = '0;
                    window    = '0;
                    bits_seen = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_report(t_id m, logic nf, logic lst);
            t_report e;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result match_index %0d none_found %0d last %0d",
                         $time, m, nf, lst);
                errors++;
                return;
            end
            e = pending_reports.pop_front();
            if (m !== e.match_index) begin
                $display("%0t: match_index expected %0d actual %0d", $time, e.match_index, m);
                errors++;
            end
            if (nf !== e.none_found) begin
                $display("%0t: none_found expected %0d actual %0d", $time, e.none_found, nf);
                errors++;
            end
            if (lst !== e.last) begin
                $display("%0t: last expected %0d actual %0d", $time, e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm = 1'b0;
    int   n_items = 0;
    hit_tracker tracker;

    bmpm_in_if  item_bus ();
    bmpm_cfg_if cfg_bus ();
    bmpm_out_if res_bus ();

    binary_multi_pattern_matcher i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .i_cfg    (cfg_bus),
        .o_result (res_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 10);
    endfunction

    task automatic send_item(t_kind kind, t_pattern value, t_id idx, logic bitv);
        while (take_break()) begin
            item_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.kind          <= kind;
        item_bus.pattern_value <= value;
        item_bus.pattern_index <= idx;
        item_bus.text_bit      <= bitv;
        @(posedge i_clk);
        while (item_bus.ready !== 1'b1) @(posedge i_clk);
        tracker.take_item(kind, value, idx, bitv);
        if (kind != KIND_UNUSED) n_items++;
        // no idling on either side through the middle of the run
        calm = (n_items >= 200 && n_items < 300);
    endtask

    task automatic send_text(logic b);
        send_item(KIND_TEXT, t_pattern'($urandom), t_id'($urandom), b);
    endtask

    task automatic send_end();
        send_item(KIND_END, t_pattern'($urandom), t_id'($urandom), 1'($urandom));
    endtask

    // idle the input and wait for every pending report word plus the lookup latency
    task automatic settle();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(t_len len);
        cfg_bus.valid          <= 1'b1;
        cfg_bus.pattern_length <= len;
        @(posedge i_clk);
        while (cfg_bus.ready !== 1'b1) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        tracker.length_reg = len;
    endtask

    task automatic run_phase();
        t_len     len;
        int       bits;
        t_pattern loaded[$];
        t_pattern v;
        t_pattern p;
        case ($urandom_range(9))
            0:       len = 5'd0;
            1:       len = 5'd1;
            2:       len = 5'd16;
            3:       len = 5'd17;
            4:       len = 5'd31;
            default: len = t_len'($urandom_range(2, 15));
        endcase
        settle();
        write_length(len);
        bits = tracker.active_bits();
        repeat ($urandom_range(1, 6)) begin
            // sometimes reload a value with a new id
            if (loaded.size() != 0 && $urandom_range(4) == 0)
                v = loaded[$urandom_range(loaded.size() - 1)];
            else
                v = t_pattern'($urandom);
            send_item(KIND_LOAD, v, t_id'($urandom), 1'($urandom));
            loaded = {loaded, v};
        end
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(9))
                0: send_item(KIND_UNUSED, t_pattern'($urandom), t_id'($urandom),
                             1'($urandom));
                1: send_item(KIND_LOAD, t_pattern'($urandom), t_id'($urandom),
                             1'($urandom));
                2, 3: repeat ($urandom_range(0, bits)) send_text(1'($urandom));
                default: begin
                    // embed a loaded pattern, first bit most significant
                    p = loaded[$urandom_range(loaded.size() - 1)];
                    for (int i = bits - 1; i >= 0; i--) send_text(p[i]);
                end
            endcase
        end
        // a phase left open carries its window into the next length
        if ($urandom_range(99) < 85) send_end();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
            tracker.check_report(res_bus.match_index, res_bus.none_found, res_bus.last);
        res_bus.ready <= calm || ($urandom_range(99) >= 10);
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        tracker = new();
        i_rst_n                <= 1'b0;
        item_bus.valid         <= 1'b0;
        item_bus.kind          <= KIND_LOAD;
        item_bus.pattern_value <= '0;
        item_bus.pattern_index <= '0;
        item_bus.text_bit      <= 1'b0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.pattern_length <= RESET_LEN;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset length: replaced id, empty text, all-ones text
        send_item(KIND_LOAD, 16'hFFFF, 6'd63, 1'b0);
        send_item(KIND_LOAD, 16'hFFFF, 6'd62, 1'b1);
        send_item(KIND_LOAD, 16'h0000, 6'd0, 1'b0);
        send_end();
        send_item(KIND_UNUSED, 16'hFFFF, 6'd63, 1'b1);
        repeat (16) send_text(1'b1);
        send_end();

        // zero length acts as one bit; wide load value keeps its low bit
        settle();
        write_length(5'd0);
        send_item(KIND_LOAD, 16'hFFFE, 6'd0, 1'b1);
        send_item(KIND_LOAD, 16'h0001, 6'd1, 1'b0);
        send_text(1'b0);
        send_text(1'b1);
        send_end();

        while (n_items < TARGET_ITEMS) run_phase();
        send_end();
        settle();

        if (tracker.errors == 0 && tracker.pending_reports.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/bmpm_pkg.sv
rtl/bmpm_if.sv
rtl/bmpm_ctrl.sv
rtl/bmpm_dp.sv
rtl/binary_multi_pattern_matcher.sv
rtl/bmpm_checker.sv
tb/tb_top.sv
